// ===== hdl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared widths, opcodes and register map of the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int OPCODE_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int CAP_W       = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 4'd15;
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

endpackage

// ===== hdl/circular_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Bounded ring-buffer FIFO with a configurable capacity and one status result
// per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output stage is empty or m_tready
// is high, and returns its result in the cycle after acceptance; that cycle is
// the registered read of the slot RAM at the new head. The result waits in the
// output stage while m_tready is low, and a new transaction is taken in the same
// cycle the waiting result leaves. Writing the capacity register empties the
// queue. No clearing pass after reset; slot data is only used once written.
module circular_fifo_queue_core
    import cfq_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int ITEM_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode[1:0], value[33:2], zero[39:34]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accepted[0], front_value[32:1], rear_value[64:33], is_empty[65],
    // is_full[66], zero[71:67]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W     = $clog2(SLOT_COUNT);
    localparam int SLOT_LAST = SLOT_COUNT - 1;

    logic [CAP_W-1:0]     cap_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [ITEM_BITS-1:0] rear_reg, rear_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 acc_reg, acc_next;
    logic                 fwd_reg, fwd_next;

    logic [IDX_W-1:0]     ring_last;
    logic                 is_empty, is_full;
    logic                 s_fire, cfg_wr, wr_en;
    logic [OPCODE_W-1:0]  opcode;
    logic [VALUE_W-1:0]   value;
    logic [ITEM_BITS-1:0] rd_data;
    logic [VALUE_W-1:0]   front_value, rear_value;

    function automatic logic [IDX_W-1:0] ring_inc(
        input logic [IDX_W-1:0] idx,
        input logic [IDX_W-1:0] last
    );
        return (idx == last) ? '0 : idx + 1'b1;
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? PDATA_W'(cap_reg) : '0;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_CAPACITY);

    always_comb
    begin
        if (int'(cap_reg) >= SLOT_LAST)
        begin
            ring_last = IDX_W'(SLOT_LAST);
        end
        else
        begin
            ring_last = IDX_W'(cap_reg);
        end
    end

    assign is_empty = (head_reg == tail_reg);
    assign is_full  = (ring_inc(tail_reg, ring_last) == head_reg);

    assign opcode   = s_tdata[1:0];
    assign value    = s_tdata[33:2];
    assign s_tready = ~out_valid_reg | m_tready;
    assign s_fire   = s_tvalid & s_tready;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        rear_next      = rear_reg;
        acc_next       = acc_reg;
        fwd_next       = fwd_reg;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg & ~m_tready;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
            acc_next       = 1'b1;
            fwd_next       = 1'b0;
            case (opcode)
                OP_ENQUEUE:
                begin
                    if (is_full)
                    begin
                        acc_next = 1'b0;
                    end
                    else
                    begin
                        tail_next = ring_inc(tail_reg, ring_last);
                        rear_next = ITEM_BITS'(value);
                        wr_en     = 1'b1;
                        fwd_next  = is_empty;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (is_empty)
                    begin
                        acc_next = 1'b0;
                    end
                    else
                    begin
                        head_next = ring_inc(head_reg, ring_last);
                    end
                end
                default:
                begin
                    acc_next = 1'b1;
                end
            endcase
        end
    end

    cfq_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (ITEM_BITS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (ITEM_BITS'(value)),
        .rd_en   (s_fire),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            fwd_reg       <= fwd_next;
            if (cfg_wr)
            begin
                cap_reg  <= pwdata[CAP_W-1:0];
                head_reg <= '0;
                tail_reg <= '0;
            end
            else
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rear_reg <= rear_next;
    end

    always_comb
    begin
        rear_value  = is_empty ? EMPTY_VALUE : VALUE_W'(rear_reg);
        front_value = is_empty ? EMPTY_VALUE :
                      (fwd_reg ? VALUE_W'(rear_reg) : VALUE_W'(rd_data));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, is_full, is_empty, rear_value, front_value, acc_reg};

    a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= ring_last) && (tail_reg <= ring_last))
        else $error("queue index outside ring");

    a_refused_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (opcode == OP_ENQUEUE) && is_full && !cfg_wr
        |=> $stable(tail_reg) && !acc_reg)
        else $error("refused enqueue moved tail");

    a_forward_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fwd_reg |-> acc_reg && !is_empty)
        else $error("front forwarding without a stored item");

endmodule

// ===== hdl/cfq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// cfq_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfq_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
